// ----- hw/rtl/rcmv_pkg.sv -----
// ----------------------------------------------------------------------------
// rcmv_pkg
// Request and response types, widths and saturating add for the rod cutting
// block.
// ----------------------------------------------------------------------------
package rcmv_pkg;

   localparam int PRICE_FIELD_BITS = 16;
   localparam int VALUE_BITS       = 22;

   typedef struct packed {
      logic [PRICE_FIELD_BITS-1:0] price;
      logic                        last_price;
   } req_type;

   typedef struct packed {
      logic [VALUE_BITS-1:0] best_value;
      logic                  truncated;
   } rsp_type;

   function automatic logic [VALUE_BITS-1:0] sat_add(
      input logic [VALUE_BITS-1:0]       a,
      input logic [PRICE_FIELD_BITS-1:0] p
   );
      logic [VALUE_BITS:0] sum;
      sum = {1'b0, a} + (VALUE_BITS+1)'(p);
      return sum[VALUE_BITS] ? {VALUE_BITS{1'b1}} : sum[VALUE_BITS-1:0];
   endfunction

endpackage

// ----- hw/rtl/rcmv_ram.sv -----
// ----------------------------------------------------------------------------
// rcmv_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rcmv_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/rcmv_relax.sv -----
// ----------------------------------------------------------------------------
// rcmv_relax
// Table update: max of the current entry and the shorter entry plus a price.
// ----------------------------------------------------------------------------
module rcmv_relax (
   input  logic [rcmv_pkg::VALUE_BITS-1:0]       cur_value,
   input  logic [rcmv_pkg::VALUE_BITS-1:0]       base_value,
   input  logic [rcmv_pkg::PRICE_FIELD_BITS-1:0] price,
   output logic [rcmv_pkg::VALUE_BITS-1:0]       new_value
);

   logic [rcmv_pkg::VALUE_BITS-1:0] cand;

   always_comb begin
      cand      = rcmv_pkg::sat_add(base_value, price);
      new_value = (cand > cur_value) ? cand : cur_value;
   end

endmodule

// ----- hw/rtl/rod_cutting_max_value.sv -----
// ----------------------------------------------------------------------------
// rod_cutting_max_value
// Rod cutting maximum value over a price list, table held in block RAM.
// ----------------------------------------------------------------------------
// Requests carry one price each; a request is taken when start is high and
// busy is low, and the request flagged last_price closes the list. Prices
// past MAX_LEN are dropped and reported through truncated.
// A non-closing request leaves busy low. A closing request of length n
// keeps busy high while the table is built: one table update per cycle in
// a pass, held between passes for the price fetch (S_P0/S_P0W, S_PK/S_PKW),
// with two read ports on a mirrored table RAM.
// The single response appears on rsp_item with rsp_valid high for exactly
// one cycle, in the cycle busy falls; the receiver cannot hold it off.
// Reset clears the list count and the overflow flag; RAM contents are not
// cleared, since only entries written for the current list are read.
// ----------------------------------------------------------------------------
module rod_cutting_max_value #(
   parameter int MAX_LEN    = 64,
   parameter int PRICE_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  rcmv_pkg::req_type req_item,
   output logic              rsp_valid,
   output rcmv_pkg::rsp_type rsp_item
);

   localparam int VB  = rcmv_pkg::VALUE_BITS;
   localparam int FB  = rcmv_pkg::PRICE_FIELD_BITS;
   localparam int PW  = (PRICE_BITS < FB) ? PRICE_BITS : FB;
   localparam int APW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int CW  = $clog2(MAX_LEN + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_P0, S_P0W, S_INIT, S_PK, S_PKW, S_RUN, S_FIN, S_RD, S_OUT
   } state_type;

   state_type         state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              ovf_ff, ovf_in;
   logic [CW-1:0]     n_ff, n_in;
   logic [CW-1:0]     j_ff, j_in;
   logic [CW-1:0]     k_ff, k_in;
   logic [CW-1:0]     wj_ff, wj_in;
   logic              v_ff, v_in;
   logic [FB-1:0]     price_ff, price_in;
   logic [VB-1:0]     acc_ff, acc_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rcmv_pkg::rsp_type rsp_ff, rsp_in;

   logic              accept;
   logic              has_room;
   logic              p_we;
   logic [APW-1:0]    p_waddr;
   logic [PW-1:0]     p_wdata;
   logic [APW-1:0]    p_raddr;
   logic [PW-1:0]     p_rdata;
   logic              b_we;
   logic [CW-1:0]     b_waddr;
   logic [VB-1:0]     b_wdata;
   logic [CW-1:0]     b_raddr_a;
   logic [CW-1:0]     b_raddr_b;
   logic [VB-1:0]     b_rdata_a;
   logic [VB-1:0]     b_rdata_b;
   logic [VB-1:0]     relax_value;

   rcmv_ram #(.WIDTH(PW), .DEPTH(MAX_LEN), .AW(APW)) u_price_ram (
      .clock   (clock),
      .wr_en   (p_we),
      .wr_addr (p_waddr),
      .wr_data (p_wdata),
      .rd_addr (p_raddr),
      .rd_data (p_rdata)
   );

   rcmv_ram #(.WIDTH(VB), .DEPTH(MAX_LEN + 1), .AW(CW)) u_best_ram_a (
      .clock   (clock),
      .wr_en   (b_we),
      .wr_addr (b_waddr),
      .wr_data (b_wdata),
      .rd_addr (b_raddr_a),
      .rd_data (b_rdata_a)
   );

   rcmv_ram #(.WIDTH(VB), .DEPTH(MAX_LEN + 1), .AW(CW)) u_best_ram_b (
      .clock   (clock),
      .wr_en   (b_we),
      .wr_addr (b_waddr),
      .wr_data (b_wdata),
      .rd_addr (b_raddr_b),
      .rd_data (b_rdata_b)
   );

   rcmv_relax u_relax (
      .cur_value  (b_rdata_a),
      .base_value (b_rdata_b),
      .price      (price_ff),
      .new_value  (relax_value)
   );

   assign busy     = (state_ff != S_IDLE);
   assign accept   = start && (state_ff == S_IDLE);
   assign has_room = (count_ff < CW'(MAX_LEN));

   always_comb begin
      p_we      = accept && has_room;
      p_waddr   = count_ff[APW-1:0];
      p_wdata   = req_item.price[PW-1:0];
      p_raddr   = (state_ff == S_P0) ? APW'(0) : k_ff[APW-1:0];
      b_raddr_a = (state_ff == S_RD) ? n_ff : j_ff;
      b_raddr_b = j_ff - k_ff - CW'(1);
      if (state_ff == S_INIT) begin
         b_we    = 1'b1;
         b_waddr = j_ff;
         b_wdata = acc_ff;
      end else begin
         b_we    = v_ff;
         b_waddr = wj_ff;
         b_wdata = relax_value;
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      n_in         = n_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      wj_in        = j_ff;
      v_in         = 1'b0;
      price_in     = price_ff;
      acc_in       = acc_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (has_room) begin
                  count_in = count_ff + CW'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_item.last_price) begin
                  n_in     = has_room ? count_ff + CW'(1) : count_ff;
                  state_in = S_P0;
               end
            end
         end
         S_P0: begin
            state_in = S_P0W;
         end
         S_P0W: begin
            price_in = FB'(p_rdata);
            acc_in   = '0;
            j_in     = '0;
            state_in = S_INIT;
         end
         S_INIT: begin
            acc_in = rcmv_pkg::sat_add(acc_ff, price_ff);
            j_in   = j_ff + CW'(1);
            if (j_ff == n_ff) begin
               k_in     = CW'(1);
               state_in = (n_ff == CW'(1)) ? S_FIN : S_PK;
            end
         end
         S_PK: begin
            state_in = S_PKW;
         end
         S_PKW: begin
            price_in = FB'(p_rdata);
            j_in     = k_ff + CW'(1);
            state_in = S_RUN;
         end
         S_RUN: begin
            v_in  = 1'b1;
            wj_in = j_ff;
            j_in  = j_ff + CW'(1);
            if (j_ff == n_ff) begin
               k_in     = k_ff + CW'(1);
               state_in = (k_ff + CW'(1) == n_ff) ? S_FIN : S_PK;
            end
         end
         S_FIN: begin
            state_in = S_RD;
         end
         S_RD: begin
            state_in = S_OUT;
         end
         S_OUT: begin
            rsp_valid_in       = 1'b1;
            rsp_in.best_value  = b_rdata_a;
            rsp_in.truncated   = ovf_ff;
            count_in           = '0;
            ovf_in             = 1'b0;
            state_in           = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         v_ff         <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         v_ff         <= v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff     <= n_in;
      j_ff     <= j_in;
      k_ff     <= k_in;
      wj_ff    <= wj_in;
      price_ff <= price_in;
      acc_ff   <= acc_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule
